/* rtl/fmqd_pkg.sv */
// Package for the FM quadrature discriminator: payload structs, CORDIC widths,
// the arctangent table and the state carried down the CORDIC cell row.
// No dependencies.
package fmqd_pkg;

	// CORDIC iteration count; the angle table covers at most 24 iterations
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;
	localparam int CORDIC_CELLS  = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

	// Vector width covers the conjugate product after gain growth, angle is Q3.16
	localparam int XW  = 35;
	localparam int ZW  = 20;
	localparam int SHW = 5;
	localparam int GW  = 32;
	localparam int PW  = ZW + GW;

	localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic [62:0]          ENERGY_MAX  = {63{1'b1}};
	localparam logic signed [GW-1:0] GAIN_RESET  = 32'sd65536;
	localparam logic signed [ZW-1:0] DEMOD_MAX   = 20'sd32767;
	localparam logic signed [ZW-1:0] DEMOD_MIN   = -20'sd32768;

	localparam logic signed [ZW-1:0] ATAN_Q16 [ATAN_LEN] = '{
		20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
		20'sd16, 20'sd8, 20'sd4, 20'sd2, 20'sd1, 20'sd0,
		20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0
	};

	typedef struct packed {
		logic signed [15:0] sample_i;
		logic signed [15:0] sample_q;
		logic               block_end;
	} in_t;

	typedef struct packed {
		logic signed [15:0] demod_sample;
		logic               result_last;
		logic [31:0]        peak_power;
		logic [62:0]        energy_sum;
	} out_t;

	// Rotating vector plus the statistics riding along with it
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
		logic                 last;
		logic [31:0]          peak;
		logic [62:0]          energy;
	} vec_t;

endpackage

/* rtl/fmqd_front.sv */
// Front end of the discriminator: conjugate product, power statistics and
// quadrant pre-rotation ahead of the CORDIC cell row. Depends on fmqd_pkg.
module fmqd_front import fmqd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  in_t  in_data,
	output logic vec_valid,
	output vec_t vec
);

	logic               v_s1, v_s2, v_s3;
	logic signed [15:0] prev_i_q, prev_q_q;
	logic signed [15:0] ci_s1, cq_s1, pi_s1, pq_s1;
	logic               last_s1, last_s2;
	logic signed [31:0] p_ii_s2, p_qq_s2, p_qi_s2, p_iq_s2, sq_i_s2, sq_q_s2;
	logic [31:0]        peak_q;
	logic [62:0]        energy_q;
	vec_t               vec_s3;

	logic signed [32:0]   re, im;
	logic signed [XW-1:0] re_x, im_x;
	logic [31:0]          pwr, peak_nxt;
	logic [63:0]          esum;
	logic [62:0]          energy_nxt;
	vec_t                 vec_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			prev_i_q <= '0;
			prev_q_q <= '0;
			peak_q   <= '0;
			energy_q <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (in_valid) begin
				prev_i_q <= in_data.sample_i;
				prev_q_q <= in_data.sample_q;
			end
			if (v_s2) begin
				// restart statistics after the block end
				peak_q   <= last_s2 ? '0 : peak_nxt;
				energy_q <= last_s2 ? '0 : energy_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ci_s1   <= in_data.sample_i;
			cq_s1   <= in_data.sample_q;
			pi_s1   <= prev_i_q;
			pq_s1   <= prev_q_q;
			last_s1 <= in_data.block_end;
			p_ii_s2 <= ci_s1 * pi_s1;
			p_qq_s2 <= cq_s1 * pq_s1;
			p_qi_s2 <= cq_s1 * pi_s1;
			p_iq_s2 <= ci_s1 * pq_s1;
			sq_i_s2 <= ci_s1 * ci_s1;
			sq_q_s2 <= cq_s1 * cq_s1;
			last_s2 <= last_s1;
			vec_s3  <= vec_nxt;
		end
	end

	always_comb begin
		pwr        = $unsigned(sq_i_s2) + $unsigned(sq_q_s2);
		peak_nxt   = (pwr > peak_q) ? pwr : peak_q;
		esum       = {1'b0, energy_q} + {32'd0, pwr};
		energy_nxt = esum[63] ? ENERGY_MAX : esum[62:0];

		re   = 33'(p_ii_s2) + 33'(p_qq_s2);
		im   = 33'(p_qi_s2) - 33'(p_iq_s2);
		re_x = XW'(re);
		im_x = XW'(im);

		vec_nxt        = '0;
		vec_nxt.zero   = (re == '0) && (im == '0);
		vec_nxt.last   = last_s2;
		vec_nxt.peak   = last_s2 ? peak_nxt : '0;
		vec_nxt.energy = last_s2 ? energy_nxt : '0;
		// fold the left half plane onto the right one
		if (re[32]) begin
			if (!im[32]) begin
				vec_nxt.x = im_x;
				vec_nxt.y = -re_x;
				vec_nxt.z = HALF_PI_Q16;
			end else begin
				vec_nxt.x = -im_x;
				vec_nxt.y = re_x;
				vec_nxt.z = -HALF_PI_Q16;
			end
		end else begin
			vec_nxt.x = re_x;
			vec_nxt.y = im_x;
			vec_nxt.z = '0;
		end
	end

	assign vec_valid = v_s3;
	assign vec       = vec_s3;

endmodule

/* rtl/fmqd_cordic_cell.sv */
// One vectoring CORDIC iteration with its own register; cells chain into a row.
// Depends on fmqd_pkg.
module fmqd_cordic_cell import fmqd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [SHW-1:0]       shift,
	input  logic signed [ZW-1:0] step,
	input  logic                 vec_in_valid,
	input  vec_t                 vec_in,
	output logic                 vec_out_valid,
	output vec_t                 vec_out
);

	logic                 valid_q;
	vec_t                 vec_q;
	vec_t                 vec_nxt;
	logic signed [XW-1:0] xs, ys;

	always_comb begin
		xs      = vec_in.x >>> shift;
		ys      = vec_in.y >>> shift;
		vec_nxt = vec_in;
		// drive y toward zero
		if (!vec_in.y[XW-1]) begin
			vec_nxt.x = vec_in.x + ys;
			vec_nxt.y = vec_in.y - xs;
			vec_nxt.z = vec_in.z + step;
		end else begin
			vec_nxt.x = vec_in.x - ys;
			vec_nxt.y = vec_in.y + xs;
			vec_nxt.z = vec_in.z - step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vec_in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q <= vec_nxt;
		end
	end

	assign vec_out_valid = valid_q;
	assign vec_out       = vec_q;

endmodule

/* rtl/fmqd_back.sv */
// Back end: angle times gain, truncation toward zero, 16-bit saturation and the
// result register. Depends on fmqd_pkg.
module fmqd_back import fmqd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic signed [GW-1:0] gain,
	input  logic                 vec_valid,
	input  vec_t                 vec,
	output logic                 out_valid,
	output out_t                 out_data
);

	logic                 v_s1, out_valid_q;
	logic signed [PW-1:0] prod_s1;
	logic                 last_s1;
	logic [31:0]          peak_s1;
	logic [62:0]          energy_s1;
	out_t                 out_q;

	logic signed [ZW-1:0] ang, quo, quo_t;
	out_t                 out_nxt;

	assign ang = vec.zero ? '0 : vec.z;

	always_comb begin
		quo = prod_s1[PW-1:GW];
		// floor to truncation for negative products with a remainder
		quo_t = (prod_s1[PW-1] && (prod_s1[GW-1:0] != '0)) ? quo + 20'sd1 : quo;
		out_nxt.result_last = last_s1;
		out_nxt.peak_power  = peak_s1;
		out_nxt.energy_sum  = energy_s1;
		if (quo_t > DEMOD_MAX) begin
			out_nxt.demod_sample = 16'sh7fff;
		end else if (quo_t < DEMOD_MIN) begin
			out_nxt.demod_sample = 16'sh8000;
		end else begin
			out_nxt.demod_sample = quo_t[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= vec_valid;
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1   <= ang * gain;
			last_s1   <= vec.last;
			peak_s1   <= vec.peak;
			energy_s1 <= vec.energy;
			out_q     <= out_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/fm_quadrature_discriminator_unit.sv */
// FM quadrature discriminator. Each request carries one signed 16-bit I/Q sample
// and yields exactly one result: the phase of the sample times the conjugate of
// the previous sample, found by a row of CORDIC_CELLS vectoring CORDIC cells,
// scaled by the signed Q16.16 demod gain, truncated toward zero and saturated
// to 16 bits. The block also keeps the peak and the saturating sum of I*I+Q*Q
// and reports them on the request marked block_end, then restarts them; the
// previous sample carries across blocks. One request enters per clock and the
// result passes three front stages (capture, multiply, product sum with
// pre-rotation), one register per CORDIC cell, the gain multiplier and the
// result register. The whole pipeline advances together, so a result left
// waiting at the output holds every stage and in_ready drops until it is taken.
// Write demod_gain only while idle.
// Depends on fmqd_pkg, fmqd_front, fmqd_cordic_cell and fmqd_back.
module fm_quadrature_discriminator_unit import fmqd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic signed [GW-1:0] cfg_wdata
);

	logic                 en;
	logic signed [GW-1:0] gain_q;
	logic                 row_valid [CORDIC_CELLS+1];
	vec_t                 row_vec   [CORDIC_CELLS+1];

	// Advance every stage unless a finished result is still waiting
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Hold the gain register; reset to unity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// Conjugate product, statistics and quadrant fold
	fmqd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.vec_valid (row_valid[0]),
		.vec       (row_vec[0])
	);

	// Row of CORDIC cells, one iteration per cell
	for (genvar k = 0; k < CORDIC_CELLS; k++) begin : g_cell
		fmqd_cordic_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.en            (en),
			.shift         (SHW'(k)),
			.step          (ATAN_Q16[k]),
			.vec_in_valid  (row_valid[k]),
			.vec_in        (row_vec[k]),
			.vec_out_valid (row_valid[k+1]),
			.vec_out       (row_vec[k+1])
		);
	end

	// Gain, rounding and the result register
	fmqd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.gain      (gain_q),
		.vec_valid (row_valid[CORDIC_CELLS]),
		.vec       (row_vec[CORDIC_CELLS]),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// Statistics appear only on the closing result
	a_stats_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.result_last |->
			out_data.peak_power == '0 && out_data.energy_sum == '0)
		else $error("statistics on a result that does not close a block");

	// The block sum always covers its own peak
	a_energy_covers_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_last |->
			{31'd0, out_data.peak_power} <= out_data.energy_sum)
		else $error("energy sum below peak power");

	// A waiting result blocks new requests
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request accepted while a result waits");

	// The end of the row moves only when the pipeline advances
	a_row_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(row_valid[CORDIC_CELLS]))
		else $error("CORDIC row moved during a stall");

endmodule
